// ===== design/assert_macros.svh =====
// Assertion helpers for the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// Same-cycle implication outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked a fixed number of cycles later.
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

// ===== design/ccre_pkg.sv =====
package ccre_pkg;

	// Geometry of the point table and of the fixed-point formats.
	localparam int MAX_POINTS      = 16;
	localparam int COORD_WIDTH     = 16;
	localparam int PARAM_FRAC_BITS = 16;
	localparam int AXES            = 3;
	localparam int LANES           = 4;
	localparam int IDX_W           = $clog2(MAX_POINTS);
	localparam int CNT_W           = 5;
	localparam int PIDX_W          = 4;
	localparam int PARAM_W         = 32;
	localparam int WHOLE_W         = PARAM_W - PARAM_FRAC_BITS;
	localparam int WHOLE_LO_W      = WHOLE_W / 2;
	localparam int DIR_W           = COORD_WIDTH + 5;
	localparam int W_W             = PARAM_FRAC_BITS + 6;
	localparam int P_W             = COORD_WIDTH + W_W;
	localparam int S_W             = P_W + 2;
	localparam int CFG_W           = 16;
	localparam int REG_IDX_W       = 2;
	localparam int RESET_COUNT     = 13;

	// Cycles from the accepting edge to the cycle in which done is high.
	localparam int LATENCY = 6;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_X     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_START_Y     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_START_Z     = 2'd3;

	// Output saturation bounds.
	localparam longint POS_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;
	localparam longint DIR_MAX = (longint'(1) << (DIR_W - 1)) - 1;
	localparam longint DIR_MIN = -DIR_MAX - 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef coord_t [AXES-1:0] point_t;
	typedef logic signed [W_W-1:0] weight_t;
	typedef logic signed [P_W-1:0] prod_t;
	typedef logic signed [S_W-1:0] sum_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Builds one table entry from three integer coordinates.
	function automatic point_t make_point(input int x, input int y, input int z);
		point_t p;
		p[0] = COORD_WIDTH'(x);
		p[1] = COORD_WIDTH'(y);
		p[2] = COORD_WIDTH'(z);
		return p;
	endfunction

	// Contents of the point table after reset: the built-in loop, rest zero.
	function automatic point_t init_point(input idx_t idx);
		point_t p;
		case (idx)
			0:  p = make_point(-7834,   666,   1178);
			1:  p = make_point(-5478,   128,  -1126);
			2:  p = make_point(-2509, -1101,  -4813);
			3:  p = make_point( 1510,   538,  -2458);
			4:  p = make_point( 3482,   691,   2483);
			5:  p = make_point(-2176,  -486,   6298);
			6:  p = make_point(-6016,  1946,  -1587);
			7:  p = make_point(-2534,  1894,  -9498);
			8:  p = make_point( 1510,  6298, -10598);
			9:  p = make_point( 4096,  3174,  -2765);
			10: p = make_point( 2278,  -179,   3686);
			11: p = make_point( 3840,   256,   2304);
			12: p = make_point( 6400,   486,   1536);
			default: p = '0;
		endcase
		return p;
	endfunction

	// One step of restoring remainder: shift in a bit, subtract n if it fits.
	function automatic idx_t mod_step(input idx_t r, input logic b, input cnt_t n);
		logic [IDX_W:0] t;
		t = {r, b};
		if (t >= (IDX_W+1)'(n)) begin
			t = t - (IDX_W+1)'(n);
		end
		return t[IDX_W-1:0];
	endfunction

	// Saturation of a rounded sum to the position width.
	function automatic coord_t sat_pos(input sum_t v);
		coord_t r;
		if (v > POS_MAX) begin
			r = COORD_WIDTH'(POS_MAX);
		end else if (v < POS_MIN) begin
			r = COORD_WIDTH'(POS_MIN);
		end else begin
			r = COORD_WIDTH'(v);
		end
		return r;
	endfunction

	// Saturation of a rounded sum to the tangent width.
	function automatic logic signed [DIR_W-1:0] sat_dir(input sum_t v);
		logic signed [DIR_W-1:0] r;
		if (v > DIR_MAX) begin
			r = DIR_W'(DIR_MAX);
		end else if (v < DIR_MIN) begin
			r = DIR_W'(DIR_MIN);
		end else begin
			r = DIR_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== design/closed_catmull_rom_evaluator_top.sv =====
// Closed-loop uniform Catmull-Rom evaluator, 3D, signed Q7.8 coordinates.
// Requests enter on start with command, point_index, point_x/y/z and
// curve_param; busy is always low, so a request is taken on every cycle in
// which start is high. A load request (command 0) writes one control point
// and gives no result. An evaluate request (command 1) takes t in Q16.16 and
// gives one result: pos_x/y/z (position plus start offset) and dir_x/y/z
// (unnormalized tangent), both saturated, shown with done for one cycle.
// One request per cycle is sustained. The pipeline depth comes from a
// two-stage remainder of the integer part of t, the u^2 and u^3
// multiplies, the four-port point table read, the basis multiplies and the
// sum, round and saturate stages.
// Loads write the table in the same stage where evaluates read it, so every
// request sees exactly the loads that were accepted before it.
// The configuration port (cfg_we, cfg_index, cfg_data) writes point_count or
// start_x/y/z; the user must use it only while no request is in flight, as
// the block does not enforce it. Reset clears the pipeline valid bits, sets
// point_count to 13, the offsets to zero and marks all table slots unwritten,
// so they read the built-in thirteen-point loop and zeros; no clearing pass.
// The receiver cannot stall: done and the result ports are valid one cycle.
module closed_catmull_rom_evaluator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [ccre_pkg::PIDX_W-1:0]          point_index,
	input  logic signed [ccre_pkg::COORD_WIDTH-1:0] point_x,
	input  logic signed [ccre_pkg::COORD_WIDTH-1:0] point_y,
	input  logic signed [ccre_pkg::COORD_WIDTH-1:0] point_z,
	input  logic [ccre_pkg::PARAM_W-1:0]         curve_param,
	input  logic                                 cfg_we,
	input  logic [ccre_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [ccre_pkg::CFG_W-1:0]           cfg_data,
	output logic                                 done,
	output logic signed [ccre_pkg::COORD_WIDTH-1:0] pos_x,
	output logic signed [ccre_pkg::COORD_WIDTH-1:0] pos_y,
	output logic signed [ccre_pkg::COORD_WIDTH-1:0] pos_z,
	output logic signed [ccre_pkg::DIR_W-1:0]    dir_x,
	output logic signed [ccre_pkg::DIR_W-1:0]    dir_y,
	output logic signed [ccre_pkg::DIR_W-1:0]    dir_z
);
	import ccre_pkg::*;

	localparam int F = PARAM_FRAC_BITS;
	localparam int ONE = 1 << F;
	localparam sum_t RND_POS = sum_t'(longint'(1) << F);
	localparam sum_t RND_DIR = sum_t'(longint'(1) << (F - 1));

	// Configuration registers.
	cnt_t   point_count_q;
	coord_t start_q [AXES];
	cnt_t   n_eff;

	// Point table: a load writes one slot, the four lanes read their own slots.
	point_t pt_mem [MAX_POINTS];
	logic   [MAX_POINTS-1:0] written_q;

	// Stage 1: captured request.
	logic                     vld_s1, cmd_s1;
	logic [PARAM_W-1:0]       par_s1;
	logic [PIDX_W-1:0]        pidx_s1;
	point_t                   pxyz_s1;

	// Stage 2: upper remainder and u^2.
	logic                     vld_s2, cmd_s2;
	idx_t                     rem_s2;
	logic [WHOLE_LO_W-1:0]    lo_s2;
	logic [F-1:0]             u_s2, u2_s2;
	logic [PIDX_W-1:0]        pidx_s2;
	point_t                   pxyz_s2;

	// Stage 3: segment index and u^3; table write or read happens here.
	logic                     vld_s3, cmd_s3;
	idx_t                     whole_s3;
	logic [F-1:0]             u_s3, u2_s3, u3_s3;
	logic [PIDX_W-1:0]        pidx_s3;
	point_t                   pxyz_s3;

	// Stage 4: fetched points and basis weights.
	logic                     ev_s4;
	point_t                   rd_s4 [LANES];
	logic   [LANES-1:0]       rv_s4;
	idx_t                     ri_s4 [LANES];
	weight_t                  pw_s4 [LANES];
	weight_t                  dw_s4 [LANES];

	// Stage 5: products.
	logic                     ev_s5;
	prod_t                    pp_s5 [AXES][LANES];
	prod_t                    dp_s5 [AXES][LANES];

	// Stage 6: sums with rounding bias.
	logic                     ev_s6;
	sum_t                     ps_s6 [AXES];
	sum_t                     ds_s6 [AXES];

	// Output registers.
	logic                     done_q;
	coord_t                   pos_q [AXES];
	logic signed [DIR_W-1:0]  dir_q [AXES];

	// Combinational helpers.
	logic                     accept;
	logic                     load_s3, eval_s3, slot_ok_s3;
	idx_t                     slot_s3;
	idx_t                     rem_hi, whole_lo;
	logic [2*F-1:0]           u_sq, u_cube;
	idx_t                     lane_idx [LANES];
	weight_t                  pw [LANES];
	weight_t                  dw [LANES];
	point_t                   pt_s4 [LANES];

	// Every cycle can take a request.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Point count clamped to the legal loop sizes.
	always_comb begin
		if (point_count_q < cnt_t'(LANES)) begin
			n_eff = cnt_t'(LANES);
		end else if (point_count_q > cnt_t'(MAX_POINTS)) begin
			n_eff = cnt_t'(MAX_POINTS);
		end else begin
			n_eff = point_count_q;
		end
	end

	// Stage 1 logic: remainder over the upper byte of the integer part, u^2.
	always_comb begin
		rem_hi = '0;
		for (int i = PARAM_W - 1; i >= F + WHOLE_LO_W; i--) begin
			rem_hi = mod_step(rem_hi, par_s1[i], n_eff);
		end
		u_sq = par_s1[F-1:0] * par_s1[F-1:0];
	end

	// Stage 2 logic: remainder over the lower byte, u^3.
	always_comb begin
		whole_lo = rem_s2;
		for (int i = WHOLE_LO_W - 1; i >= 0; i--) begin
			whole_lo = mod_step(whole_lo, lo_s2[i], n_eff);
		end
		u_cube = u2_s2 * u_s2;
	end

	// Stage 3 logic: four wrapped indexes and the two sets of basis weights.
	always_comb begin
		int ui, u2i, u3i;
		logic [IDX_W:0] s;
		ui  = int'(u_s3);
		u2i = int'(u2_s3);
		u3i = int'(u3_s3);
		for (int l = 0; l < LANES; l++) begin
			s = {1'b0, whole_s3} + (IDX_W+1)'(l);
			if (s >= (IDX_W+1)'(n_eff)) begin
				s = s - (IDX_W+1)'(n_eff);
			end
			lane_idx[l] = s[IDX_W-1:0];
		end
		pw[0] = W_W'(-u3i + 2*u2i - ui);
		pw[1] = W_W'(3*u3i - 5*u2i + 2*ONE);
		pw[2] = W_W'(-3*u3i + 4*u2i + ui);
		pw[3] = W_W'(u3i - u2i);
		dw[0] = W_W'(-3*u2i + 4*ui - ONE);
		dw[1] = W_W'(9*u2i - 10*ui);
		dw[2] = W_W'(-9*u2i + 8*ui + ONE);
		dw[3] = W_W'(3*u2i - 2*ui);
	end

	assign load_s3    = vld_s3 && (cmd_s3 == CMD_LOAD);
	assign eval_s3    = vld_s3 && (cmd_s3 == CMD_EVAL);
	assign slot_ok_s3 = 32'(pidx_s3) < MAX_POINTS;
	assign slot_s3    = pidx_s3[IDX_W-1:0];

	// Stage 4 logic: an unwritten slot reads its reset contents.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			pt_s4[l] = rv_s4[l] ? rd_s4[l] : init_point(ri_s4[l]);
		end
	end

	// Control state: configuration, slot written flags, pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= cnt_t'(RESET_COUNT);
			for (int a = 0; a < AXES; a++) begin
				start_q[a] <= '0;
			end
			written_q <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			ev_s4     <= 1'b0;
			ev_s5     <= 1'b0;
			ev_s6     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POINT_COUNT: point_count_q <= cfg_data[CNT_W-1:0];
					REG_START_X:     start_q[0]    <= coord_t'(cfg_data);
					REG_START_Y:     start_q[1]    <= coord_t'(cfg_data);
					REG_START_Z:     start_q[2]    <= coord_t'(cfg_data);
					default: ;
				endcase
			end
			if (load_s3 && slot_ok_s3) begin
				written_q[slot_s3] <= 1'b1;
			end
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			ev_s4  <= eval_s3;
			ev_s5  <= ev_s4;
			ev_s6  <= ev_s5;
			done_q <= ev_s6;
		end
	end

	// Point table: a load writes its slot, each lane reads its own slot.
	always_ff @(posedge clk) begin
		if (load_s3 && slot_ok_s3) begin
			pt_mem[slot_s3] <= pxyz_s3;
		end
		for (int l = 0; l < LANES; l++) begin
			rd_s4[l] <= pt_mem[lane_idx[l]];
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		cmd_s1  <= command;
		par_s1  <= curve_param;
		pidx_s1 <= point_index;
		pxyz_s1 <= {point_z, point_y, point_x};

		cmd_s2  <= cmd_s1;
		rem_s2  <= rem_hi;
		lo_s2   <= par_s1[F +: WHOLE_LO_W];
		u_s2    <= par_s1[F-1:0];
		u2_s2   <= u_sq[2*F-1:F];
		pidx_s2 <= pidx_s1;
		pxyz_s2 <= pxyz_s1;

		cmd_s3   <= cmd_s2;
		whole_s3 <= whole_lo;
		u_s3     <= u_s2;
		u2_s3    <= u2_s2;
		u3_s3    <= u_cube[2*F-1:F];
		pidx_s3  <= pidx_s2;
		pxyz_s3  <= pxyz_s2;

		for (int l = 0; l < LANES; l++) begin
			rv_s4[l] <= written_q[lane_idx[l]];
			ri_s4[l] <= lane_idx[l];
			pw_s4[l] <= pw[l];
			dw_s4[l] <= dw[l];
		end

		for (int a = 0; a < AXES; a++) begin
			for (int l = 0; l < LANES; l++) begin
				pp_s5[a][l] <= pt_s4[l][a] * pw_s4[l];
				dp_s5[a][l] <= pt_s4[l][a] * dw_s4[l];
			end
		end

		for (int a = 0; a < AXES; a++) begin
			ps_s6[a] <= sum_t'(pp_s5[a][0]) + sum_t'(pp_s5[a][1])
				+ sum_t'(pp_s5[a][2]) + sum_t'(pp_s5[a][3]) + RND_POS;
			ds_s6[a] <= sum_t'(dp_s5[a][0]) + sum_t'(dp_s5[a][1])
				+ sum_t'(dp_s5[a][2]) + sum_t'(dp_s5[a][3]) + RND_DIR;
		end

		// Shift out the fraction, add the start offset to the position, saturate.
		for (int a = 0; a < AXES; a++) begin
			pos_q[a] <= sat_pos((ps_s6[a] >>> (F + 1)) + sum_t'(start_q[a]));
			dir_q[a] <= sat_dir(ds_s6[a] >>> F);
		end
	end

	assign done  = done_q;
	assign pos_x = pos_q[0];
	assign pos_y = pos_q[1];
	assign pos_z = pos_q[2];
	assign dir_x = dir_q[0];
	assign dir_y = dir_q[1];
	assign dir_z = dir_q[2];

endmodule

// ===== design/ccre_checker.sv =====
`include "assert_macros.svh"

// Port-level checks of request and result timing.
module ccre_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic command,
	input logic done
);
	import ccre_pkg::*;

	logic eval_req, load_req;

	assign eval_req = start && !busy && (command == CMD_EVAL);
	assign load_req = start && !busy && (command == CMD_LOAD);

	// The block can take a request in every cycle.
	`ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy, "busy went high")

	// Every evaluate request yields a result, taken at the edge after done rises.
	`ASSERT_DELAYED(a_eval_done, clk, arst_n, eval_req, (LATENCY + 1), done, "evaluate lost")

	// A load request never yields a result.
	`ASSERT_DELAYED(a_load_quiet, clk, arst_n, load_req, (LATENCY + 1), !done, "load gave a result")

	// No result appears without a matching evaluate request.
	`ASSERT_IMPLIES(a_done_src, clk, arst_n, done, $past(eval_req, LATENCY + 1), "result invented")

endmodule

bind closed_catmull_rom_evaluator_top ccre_checker u_ccre_checker (.*);
